// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the bubble sort block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BSB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bubble sort block: property violated");

// next-cycle implication, disabled while reset is asserted
`define BSB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bubble sort block: property violated");

`endif

// File: rtl/bsb_pkg.sv
// Package of the bubble sort block: sizes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package bsb_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SORT_START,
    S_SORT_FIRST,
    S_SORT_RUN,
    S_SORT_TAIL,
    S_EMIT_RD,
    S_EMIT_LOAD
  } state_t;

  typedef struct packed {
    logic idle;
    logic load_wr;
    logic sort_start;
    logic sort_first;
    logic sort_step;
    logic sort_tail;
    logic emit_rd;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic count_nz;
    logic step_last;
    logic pass_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/bsb_in_if.sv
// Input channel of the bubble sort block: valid/ready plus one element.
// Depends on bsb_pkg.
interface bsb_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [bsb_pkg::VAL_W-1:0] value;
  logic                             last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// File: rtl/bsb_out_if.sv
// Result channel of the bubble sort block: valid/ready plus one sorted element.
// Depends on bsb_pkg.
interface bsb_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bsb_pkg::VAL_W-1:0] sorted_value;
  logic                             end_of_run;
  logic                             dropped;

  modport source (output valid, output sorted_value, output end_of_run, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, input dropped,
                  output ready);
endinterface

// File: rtl/bubble_sort_block_core.sv
// Top level of the bubble sort block: joins controller and datapath to the
// input and result channels. Depends on bsb_pkg, bsb_in_if, bsb_out_if,
// bsb_ctrl and bsb_dp.
//
// Use: send the elements of a set on in_ch, one signed 32-bit value per item,
// and mark the final one with last. Elements are taken one per cycle and
// written to a 64-entry RAM; elements beyond 64 are discarded and the run is
// flagged dropped. The last item starts the sort; in_ch.ready stays low until
// the final result has been loaded into the output register.
// Sort: n-1 passes over the n stored elements in the RAM, one compare-and-swap
// per cycle through a single read and a single write port; each pass runs
// S_SORT_START, S_SORT_FIRST, S_SORT_RUN, S_SORT_TAIL (none for one element).
// Emit: results leave on out_ch in ascending order, end_of_run on the largest;
// each is read from the RAM in S_EMIT_RD once the output register is free,
// loaded into it in S_EMIT_LOAD and held there while the receiver stalls.
// A new set may be loaded while the final result of the previous run waits.
// Reset (rst_n low, synchronous) empties the store and clears the flags.
module bubble_sort_block_core (
  input  logic      clk,
  input  logic      rst_n,
  bsb_in_if.sink    in_ch,
  bsb_out_if.source out_ch
);
  import bsb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_ch.value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_sorted_value (out_ch.sorted_value),
    .out_end_of_run   (out_ch.end_of_run),
    .out_dropped      (out_ch.dropped)
  );

endmodule

// File: rtl/bsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/bsb_ctrl.sv
// Controller of the bubble sort block: load, sort-pass and emit sequencing.
// Depends on bsb_pkg; drives the datapath through cmd_t, reads sts_t.
module bsb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  bsb_pkg::sts_t  sts,
  output bsb_pkg::cmd_t  cmd
);
  import bsb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = sts.count_nz ? S_SORT_START : S_EMIT_RD;
        end
      end
      S_SORT_START: state_nxt = S_SORT_FIRST;
      S_SORT_FIRST: state_nxt = S_SORT_RUN;
      S_SORT_RUN: begin
        if (sts.step_last) begin
          state_nxt = S_SORT_TAIL;
        end
      end
      S_SORT_TAIL: state_nxt = sts.pass_last ? S_EMIT_RD : S_SORT_START;
      S_EMIT_RD: begin
        if (sts.out_free) begin
          state_nxt = S_EMIT_LOAD;
        end
      end
      S_EMIT_LOAD: state_nxt = sts.step_last ? S_LOAD : S_EMIT_RD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready    = 1'b1;
        cmd.idle    = 1'b1;
        cmd.load_wr = in_valid;
      end
      S_SORT_START: cmd.sort_start = 1'b1;
      S_SORT_FIRST: cmd.sort_first = 1'b1;
      S_SORT_RUN:   cmd.sort_step  = 1'b1;
      S_SORT_TAIL:  cmd.sort_tail  = 1'b1;
      S_EMIT_RD:    cmd.emit_rd    = sts.out_free;
      S_EMIT_LOAD:  cmd.emit_load  = 1'b1;
      default:      cmd          = '0;
    endcase
  end

endmodule

// File: rtl/bsb_dp.sv
// Datapath of the bubble sort block: element RAM, count, carry register,
// index and pass counters, output register. Depends on bsb_pkg and bsb_ram.
module bsb_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bsb_pkg::cmd_t                    cmd,
  output bsb_pkg::sts_t                    sts,
  input  logic signed [bsb_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bsb_pkg::VAL_W-1:0] out_sorted_value,
  output logic                             out_end_of_run,
  output logic                             out_dropped
);
  import bsb_pkg::*;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]         pass_r, pass_nxt;
  logic signed [VAL_W-1:0]  carry_r, carry_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0]  out_value_r;
  logic                     out_end_r;
  logic                     out_drop_r;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [VAL_W-1:0]         wr_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic [VAL_W-1:0]         rd_raw;
  logic signed [VAL_W-1:0]  rd_data;
  logic                     not_full;
  logic                     carry_gt;
  logic                     idx_last;

  bsb_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data  = $signed(rd_raw);
  assign not_full = (count_r < CNT_W'(MAX_ITEMS));
  assign carry_gt = (carry_r > rd_data);
  assign idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign sts.count_nz  = (count_r != '0);
  assign sts.step_last = idx_last;
  assign sts.pass_last = ((pass_r + CNT_W'(2)) == count_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[ADDR_W-1:0];
    wr_data = in_value;
    rd_addr = idx_r;
    priority if (cmd.load_wr) begin
      wr_en = not_full;
    end else if (cmd.sort_step) begin
      wr_en   = 1'b1;
      wr_addr = idx_r - ADDR_W'(1);
      wr_data = carry_gt ? rd_data : carry_r;
      rd_addr = idx_r + ADDR_W'(1);
    end else if (cmd.sort_tail) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(count_r - CNT_W'(1));
      wr_data = carry_r;
    end else if (cmd.sort_start) begin
      rd_addr = '0;
    end else if (cmd.sort_first) begin
      rd_addr = ADDR_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.idle) begin
      idx_nxt  = '0;
      pass_nxt = '0;
    end
    if (cmd.load_wr) begin
      if (not_full) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.sort_first) begin
      carry_nxt = rd_data;
      idx_nxt   = ADDR_W'(1);
    end
    if (cmd.sort_step) begin
      carry_nxt = carry_gt ? carry_r : rd_data;
      idx_nxt   = idx_r + ADDR_W'(1);
    end
    if (cmd.sort_tail) begin
      idx_nxt  = '0;
      pass_nxt = pass_r + CNT_W'(1);
    end
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + ADDR_W'(1);
      if (idx_last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (cmd.emit_load) begin
      out_value_r <= rd_data;
      out_end_r   <= idx_last;
      out_drop_r  <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_dropped      = out_drop_r;

endmodule

// File: rtl/bsb_checker.sv
// Port checker of the bubble sort block and its bind to the top level.
// Depends on bsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [bsb_pkg::VAL_W-1:0] out_sorted_value,
  input logic                             out_end_of_run
);
  import bsb_pkg::*;

  // hold a stalled result
  `BSB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `BSB_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sorted_value))
  // no loading once a set is closed
  `BSB_ASSERT_NXT(a_last_closes, clk, rst_n, in_valid && in_ready && in_last, !in_ready)
  // no loading in the middle of a run
  `BSB_ASSERT_IMP(a_run_blocks, clk, rst_n, out_valid && !out_end_of_run, !in_ready)

endmodule

bind bubble_sort_block_core bsb_checker u_bsb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_last          (in_ch.last),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_sorted_value (out_ch.sorted_value),
  .out_end_of_run   (out_ch.end_of_run)
);
